// ----- sv/qeh_pkg.sv -----
`default_nettype none
package qeh_pkg;

  localparam int unsigned QW = 6;
  localparam int unsigned CHW = 8;
  localparam int unsigned IDXW = 6;
  localparam logic [CHW-1:0] GAP_CHAR = 8'd45;
  localparam int unsigned DIV_STEPS = QW;

  // Register indexes on the configuration port (address bit 2).
  localparam logic REG_BIN_SIZE = 1'b0;
  localparam logic REG_PYRO_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_BASE = 2'd0,
    OP_END  = 2'd1,
    OP_READ = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    RESP_NONE,
    RESP_REPORT,
    RESP_READ
  } resp_e;

  // One unit of work handed from the front end to the back end.
  typedef struct packed {
    logic            count;
    logic            gap;
    logic            mis;
    logic [QW-1:0]   own_q;
    logic [QW-1:0]   charge_q;
    resp_e           resp;
    logic [IDXW-1:0] idx;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_RD,
    B_UPD,
    B_RESP
  } back_state_e;

endpackage
`default_nettype wire

// ----- sv/qeh_if.sv -----
`default_nettype none
interface qeh_in_if import qeh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [CHW-1:0]   base_char;
  logic [QW-1:0]    quality;
  logic             matched;
  logic [IDXW-1:0]  bin_index;

  modport source (output valid, opcode, base_char, quality, matched, bin_index,
                  input ready);
  modport sink (input valid, opcode, base_char, quality, matched, bin_index,
                output ready);
endinterface

interface qeh_out_if import qeh_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [31:0]   bin_total;
  logic [31:0]   bin_wrong;
  logic [31:0]   bases_done;
  logic [31:0]   good_count;
  logic [31:0]   error_count;
  logic [QW-1:0] max_quality;

  modport source (output valid, bin_total, bin_wrong, bases_done, good_count,
                  error_count, max_quality, input ready);
  modport sink (input valid, bin_total, bin_wrong, bases_done, good_count,
                error_count, max_quality, output ready);
endinterface
`default_nettype wire

// ----- sv/qeh_ram.sv -----
`default_nettype none
module qeh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/qeh_front.sv -----
`default_nettype none
module qeh_front import qeh_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic pyro_mode_i,
  qeh_in_if.sink    in_ch,
  input  wire logic full_i,
  output logic      push_o,
  output job_t      job_o
);

  logic [CHW-1:0] prev_char_q, prev_char_d;
  logic [QW-1:0]  prev_quality_q, prev_quality_d;
  logic           prev_valid_q, prev_valid_d;
  logic [CHW-1:0] cur_char_q, cur_char_d;
  logic [QW-1:0]  cur_quality_q, cur_quality_d;
  logic           cur_matched_q, cur_matched_d;
  logic           cur_valid_q, cur_valid_d;
  logic           accept;
  logic           cur_gap;
  logic [QW-1:0]  charge;

  assign in_ch.ready = !full_i;
  assign accept = in_ch.valid && in_ch.ready;
  assign cur_gap = (cur_char_q == GAP_CHAR);

  // With a following base present, an interior mismatch may move to a
  // neighbor of the same non-gap character, the previous base first.
  always_comb begin
    charge = cur_quality_q;
    if (pyro_mode_i && prev_valid_q && !cur_gap) begin
      if (cur_char_q == prev_char_q) begin
        charge = prev_quality_q;
      end else if (cur_char_q == in_ch.base_char) begin
        charge = in_ch.quality;
      end
    end
  end

  always_comb begin
    prev_char_d    = prev_char_q;
    prev_quality_d = prev_quality_q;
    prev_valid_d   = prev_valid_q;
    cur_char_d     = cur_char_q;
    cur_quality_d  = cur_quality_q;
    cur_matched_d  = cur_matched_q;
    cur_valid_d    = cur_valid_q;
    push_o         = 1'b0;
    job_o.count    = cur_valid_q;
    job_o.gap      = cur_gap;
    job_o.mis      = !cur_matched_q;
    job_o.own_q    = cur_quality_q;
    job_o.charge_q = cur_quality_q;
    job_o.resp     = RESP_NONE;
    job_o.idx      = in_ch.bin_index;
    if (accept) begin
      case (in_ch.opcode)
        OP_BASE: begin
          push_o         = cur_valid_q;
          job_o.charge_q = charge;
          prev_valid_d   = cur_valid_q;
          if (cur_valid_q) begin
            prev_char_d    = cur_char_q;
            prev_quality_d = cur_quality_q;
          end
          cur_char_d    = in_ch.base_char;
          cur_quality_d = in_ch.quality;
          cur_matched_d = in_ch.matched;
          cur_valid_d   = 1'b1;
        end
        OP_END: begin
          push_o         = 1'b1;
          job_o.resp     = RESP_REPORT;
          prev_char_d    = '0;
          prev_quality_d = '0;
          prev_valid_d   = 1'b0;
          cur_char_d     = '0;
          cur_quality_d  = '0;
          cur_matched_d  = 1'b0;
          cur_valid_d    = 1'b0;
        end
        OP_READ: begin
          push_o      = 1'b1;
          job_o.count = 1'b0;
          job_o.resp  = RESP_READ;
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_char_q    <= '0;
      prev_quality_q <= '0;
      prev_valid_q   <= 1'b0;
      cur_char_q     <= '0;
      cur_quality_q  <= '0;
      cur_matched_q  <= 1'b0;
      cur_valid_q    <= 1'b0;
    end else begin
      prev_char_q    <= prev_char_d;
      prev_quality_q <= prev_quality_d;
      prev_valid_q   <= prev_valid_d;
      cur_char_q     <= cur_char_d;
      cur_quality_q  <= cur_quality_d;
      cur_matched_q  <= cur_matched_d;
      cur_valid_q    <= cur_valid_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/qeh_queue.sv -----
`default_nettype none
module qeh_queue import qeh_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  input  wire logic pop_i,
  output job_t      job_o,
  output logic      full_o,
  output logic      empty_o
);

  job_t       ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/qeh_back.sv -----
`default_nettype none
module qeh_back import qeh_pkg::*; #(
  parameter int unsigned MAX_QV = 63,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [QW-1:0] bin_size_i,
  input  wire logic          empty_i,
  input  job_t               job_i,
  output logic               pop_o,
  qeh_out_if.source          out_ch
);

  localparam int unsigned NBINS = MAX_QV + 1;
  localparam int unsigned BIN_W = $clog2(NBINS);
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  back_state_e         state_q, state_d;
  job_t                job_q, job_d;
  logic [2*QW-1:0]     div_a_q, div_a_d, div_b_q, div_b_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [QW-1:0]       divisor;
  logic [NBINS-1:0]    tot_vld_q, tot_vld_d, wr_vld_q, wr_vld_d;
  cnt_t                base_cnt_q, base_cnt_d, good_cnt_q, good_cnt_d;
  cnt_t                err_cnt_q, err_cnt_d;
  logic [QW-1:0]       max_seen_q, max_seen_d;
  cnt_t                res_tot_q, res_tot_d, res_wr_q, res_wr_d;
  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [BIN_W-1:0]    tot_addr, wr_addr;
  cnt_t                tot_rdata, wr_rdata, tot_val, wr_val;
  logic                ram_re, tot_we, wr_we;
  logic                idx_in_range;
  logic [31:0]         o_total_q, o_wrong_q, o_base_q, o_good_q, o_err_q;
  logic [QW-1:0]       o_max_q;

  // One restoring step: remainder in the upper half, dividend turning into
  // quotient in the lower half.
  function automatic logic [2*QW-1:0] div_step(logic [2*QW-1:0] st, logic [QW-1:0] d);
    logic [QW:0] rem_sh;
    logic [QW-1:0] rem;
    logic bit_q;
    rem_sh = {st[2*QW-1:QW], st[QW-1]};
    bit_q  = (rem_sh >= {1'b0, d});
    rem    = bit_q ? QW'(rem_sh - {1'b0, d}) : QW'(rem_sh);
    return {rem, st[QW-2:0], bit_q};
  endfunction

  function automatic logic [BIN_W-1:0] clamp_bin(logic [QW-1:0] q);
    if (9'(q) > 9'(MAX_QV)) begin
      return BIN_W'(MAX_QV);
    end
    return BIN_W'(q);
  endfunction

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  assign divisor = (bin_size_i == '0) ? QW'(1) : bin_size_i;
  assign idx_in_range = (9'(job_q.idx) <= 9'(MAX_QV));
  assign tot_addr = job_q.count ? clamp_bin(div_a_q[QW-1:0]) : BIN_W'(job_q.idx);
  assign wr_addr  = job_q.count ? clamp_bin(div_b_q[QW-1:0]) : BIN_W'(job_q.idx);
  assign tot_val  = tot_vld_q[tot_addr] ? tot_rdata : '0;
  assign wr_val   = wr_vld_q[wr_addr] ? wr_rdata : '0;
  assign out_load = (state_q == B_RESP) && (!out_valid_q || out_ch.ready);

  qeh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NBINS)) u_tot_ram (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (tot_addr),
    .wdata_i (sat_inc(tot_val)),
    .re_i    (ram_re),
    .raddr_i (tot_addr),
    .rdata_o (tot_rdata)
  );

  qeh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NBINS)) u_wr_ram (
    .clk_i   (clk_i),
    .we_i    (wr_we),
    .waddr_i (wr_addr),
    .wdata_i (sat_inc(wr_val)),
    .re_i    (ram_re),
    .raddr_i (wr_addr),
    .rdata_o (wr_rdata)
  );

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    div_a_d     = div_a_q;
    div_b_d     = div_b_q;
    step_d      = step_q;
    tot_vld_d   = tot_vld_q;
    wr_vld_d    = wr_vld_q;
    base_cnt_d  = base_cnt_q;
    good_cnt_d  = good_cnt_q;
    err_cnt_d   = err_cnt_q;
    max_seen_d  = max_seen_q;
    res_tot_d   = res_tot_q;
    res_wr_d    = res_wr_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    ram_re      = 1'b0;
    tot_we      = 1'b0;
    wr_we       = 1'b0;
    if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          div_a_d = {QW'(0), job_i.own_q};
          div_b_d = {QW'(0), job_i.charge_q};
          step_d  = '0;
          if (job_i.count) begin
            state_d = B_DIV;
          end else if (job_i.resp == RESP_READ) begin
            state_d = B_RD;
          end else begin
            state_d = B_RESP;
          end
        end
      end
      B_DIV: begin
        div_a_d = div_step(div_a_q, divisor);
        div_b_d = div_step(div_b_q, divisor);
        step_d  = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = B_RD;
        end
      end
      B_RD: begin
        ram_re  = 1'b1;
        state_d = B_UPD;
      end
      B_UPD: begin
        if (job_q.count) begin
          tot_we              = 1'b1;
          tot_vld_d[tot_addr] = 1'b1;
          base_cnt_d          = sat_inc(base_cnt_q);
          if (!job_q.gap) begin
            good_cnt_d = sat_inc(good_cnt_q);
          end
          if (job_q.own_q > max_seen_q) begin
            max_seen_d = job_q.own_q;
          end
          if (job_q.mis) begin
            wr_we             = 1'b1;
            wr_vld_d[wr_addr] = 1'b1;
            err_cnt_d         = sat_inc(err_cnt_q);
          end
          state_d = (job_q.resp == RESP_REPORT) ? B_RESP : B_IDLE;
        end else begin
          res_tot_d = idx_in_range ? tot_val : '0;
          res_wr_d  = idx_in_range ? wr_val : '0;
          state_d   = B_RESP;
        end
      end
      B_RESP: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      tot_vld_q   <= '0;
      wr_vld_q    <= '0;
      base_cnt_q  <= '0;
      good_cnt_q  <= '0;
      err_cnt_q   <= '0;
      max_seen_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      tot_vld_q   <= tot_vld_d;
      wr_vld_q    <= wr_vld_d;
      base_cnt_q  <= base_cnt_d;
      good_cnt_q  <= good_cnt_d;
      err_cnt_q   <= err_cnt_d;
      max_seen_q  <= max_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    div_a_q   <= div_a_d;
    div_b_q   <= div_b_d;
    res_tot_q <= res_tot_d;
    res_wr_q  <= res_wr_d;
    if (out_load) begin
      o_total_q <= (job_q.resp == RESP_READ) ? 32'(res_tot_q) : '0;
      o_wrong_q <= (job_q.resp == RESP_READ) ? 32'(res_wr_q) : '0;
      o_base_q  <= 32'(base_cnt_q);
      o_good_q  <= 32'(good_cnt_q);
      o_err_q   <= 32'(err_cnt_q);
      o_max_q   <= max_seen_q;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.bin_total   = o_total_q;
  assign out_ch.bin_wrong   = o_wrong_q;
  assign out_ch.bases_done  = o_base_q;
  assign out_ch.good_count  = o_good_q;
  assign out_ch.error_count = o_err_q;
  assign out_ch.max_quality = o_max_q;

endmodule
`default_nettype wire

// ----- sv/quality_error_histogram_unit.sv -----
// Counting: a base item is counted when the next base or an end beat arrives;
// the back end dequeues it, runs 6 divider steps, then a RAM read and a write.
// A read beat takes a RAM read, an update and a response state after dequeue;
// an end beat goes to response, via divider, read and update if it flushes a base.
// Each job ends before the next is dequeued; the bit-serial divider paces bases.
// Reset: asynchronous, active low; histograms read as zero through valid bits.
`default_nettype none
module quality_error_histogram_unit import qeh_pkg::*; #(
  parameter int unsigned MAX_QV = 63,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  qeh_in_if.sink           in_ch,
  qeh_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // The front end holds the three-base window and turns each accepted beat
  // into a job: count a base (with its own and its charged quality), report
  // the counters, or read one bin. The back end divides the qualities into
  // bins and does the read-modify-write of both histograms in block RAM.
  // A two-entry queue between them lets the front keep taking beats while
  // the back end is busy.

  logic [QW-1:0] bin_size_q;
  logic          pyro_mode_q;
  logic          cfg_we;
  logic          push, pop, full, empty;
  job_t          push_job, pop_job;

  // Configuration: register index sits in address bit 2; writes land on the
  // access phase. The user must change both registers only while idle; not enforced.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_size_q  <= QW'(1);
      pyro_mode_q <= 1'b0;
    end else if (cfg_we) begin
      if (paddr[2] == REG_BIN_SIZE) begin
        bin_size_q <= pwdata[QW-1:0];
      end else begin
        pyro_mode_q <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_PYRO_MODE) ? {31'b0, pyro_mode_q}
                                              : {{(32-QW){1'b0}}, bin_size_q};

  qeh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pyro_mode_i (pyro_mode_q),
    .in_ch       (in_ch),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  qeh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (pop_job),
    .full_o  (full),
    .empty_o (empty)
  );

  qeh_back #(
    .MAX_QV      (MAX_QV),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bin_size_i (bin_size_q),
    .empty_i    (empty),
    .job_i      (pop_job),
    .pop_o      (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// ----- test/qeh_histogram_checker.sv -----
`timescale 1ns / 1ps
module qeh_histogram_checker import qeh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  qeh_in_if                in_mon,
  qeh_out_if               out_mon,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic        pready_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      reports_o
);

  localparam int unsigned MAX_QV = 63;
  localparam int unsigned NUM_BINS = MAX_QV + 1;
  localparam int unsigned BIN_W = $clog2(NUM_BINS);
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [31:0]   bin_total;
    logic [31:0]   bin_wrong;
    logic [31:0]   bases_done;
    logic [31:0]   good_count;
    logic [31:0]   error_count;
    logic [QW-1:0] max_quality;
  } report_t;

  // Shadow copy of the configuration registers.
  logic [QW-1:0]  bin_size;
  logic           pyro_mode;

  // Three-base window: previous base, middle base, and the incoming beat.
  logic [CHW-1:0] prev_ch;
  logic [QW-1:0]  prev_q;
  logic           prev_ok;
  logic [CHW-1:0] cur_ch;
  logic [QW-1:0]  cur_q;
  logic           cur_match;
  logic           cur_ok;

  logic [31:0]    total_hist [NUM_BINS];
  logic [31:0]    wrong_hist [NUM_BINS];
  logic [31:0]    bases;
  logic [31:0]    good_bases;
  logic [31:0]    err_bases;
  logic [QW-1:0]  top_q;

  report_t        expected_reports [$];
  int unsigned    fails;
  int unsigned    reports_seen;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v >= COUNT_MAX) ? COUNT_MAX : v + 32'd1;
  endfunction

  function automatic logic [BIN_W-1:0] bin_for(input logic [QW-1:0] q);
    int unsigned divisor;
    int unsigned b;
    divisor = (bin_size == '0) ? 1 : bin_size;
    b = q / divisor;
    if (b > MAX_QV) b = MAX_QV;
    return BIN_W'(b);
  endfunction

  function automatic report_t make_report(input logic [31:0] tot, input logic [31:0] wr);
    return '{bin_total: tot, bin_wrong: wr, bases_done: bases, good_count: good_bases,
             error_count: err_bases, max_quality: top_q};
  endfunction

  task automatic clear_model();
    bin_size = 6'd1;
    pyro_mode = 1'b0;
    prev_ch = '0;
    prev_q = '0;
    prev_ok = 1'b0;
    cur_ch = '0;
    cur_q = '0;
    cur_match = 1'b0;
    cur_ok = 1'b0;
    total_hist = '{default: '0};
    wrong_hist = '{default: '0};
    bases = '0;
    good_bases = '0;
    err_bases = '0;
    top_q = '0;
  endtask

  // Counts the base leaving the middle of the window.
  task automatic count_middle(input logic has_next, input logic [CHW-1:0] next_ch,
                              input logic [QW-1:0] next_q);
    logic [QW-1:0] charge_q;
    logic [BIN_W-1:0] b;
    bases = sat_inc(bases);
    if (cur_ch != GAP_CHAR) good_bases = sat_inc(good_bases);
    if (cur_q > top_q) top_q = cur_q;
    b = bin_for(cur_q);
    total_hist[b] = sat_inc(total_hist[b]);
    if (!cur_match) begin
      charge_q = cur_q;
      // Only an interior, non-gap mismatch is charged to a neighbor.
      if (pyro_mode && prev_ok && has_next && cur_ch != GAP_CHAR) begin
        if (cur_ch == prev_ch) charge_q = prev_q;
        else if (cur_ch == next_ch) charge_q = next_q;
      end
      b = bin_for(charge_q);
      wrong_hist[b] = sat_inc(wrong_hist[b]);
      err_bases = sat_inc(err_bases);
    end
  endtask

  task automatic apply_input_beat(input logic [1:0] op, input logic [CHW-1:0] ch,
                                  input logic [QW-1:0] q, input logic m,
                                  input logic [IDXW-1:0] idx);
    case (op)
      OP_BASE: begin
        if (cur_ok) begin
          count_middle(1'b1, ch, q);
          prev_ch = cur_ch;
          prev_q = cur_q;
          prev_ok = 1'b1;
        end else begin
          prev_ok = 1'b0;
        end
        cur_ch = ch;
        cur_q = q;
        cur_match = m;
        cur_ok = 1'b1;
      end
      OP_END: begin
        if (cur_ok) count_middle(1'b0, '0, '0);
        prev_ch = '0;
        prev_q = '0;
        prev_ok = 1'b0;
        cur_ch = '0;
        cur_q = '0;
        cur_match = 1'b0;
        cur_ok = 1'b0;
        expected_reports.push_back(make_report('0, '0));
      end
      OP_READ: begin
        if (idx <= MAX_QV) expected_reports.push_back(make_report(total_hist[idx], wrong_hist[idx]));
        else expected_reports.push_back(make_report('0, '0));
      end
      default: begin
      end
    endcase
  endtask

  task automatic flag_failure(input string what, input report_t want, input report_t got);
    if (fails < SHOWN_MISMATCHES) begin
      $display("[%0t] mismatch: %s", $realtime, what);
      $display("  expected total=%0d wrong=%0d bases=%0d good=%0d errors=%0d maxq=%0d",
               want.bin_total, want.bin_wrong, want.bases_done, want.good_count,
               want.error_count, want.max_quality);
      $display("  actual   total=%0d wrong=%0d bases=%0d good=%0d errors=%0d maxq=%0d",
               got.bin_total, got.bin_wrong, got.bases_done, got.good_count,
               got.error_count, got.max_quality);
    end
    fails++;
  endtask

  task automatic check_report(input report_t got);
    report_t want;
    string diff;
    if (expected_reports.size() == 0) begin
      flag_failure("result beat with nothing expected", '0, got);
    end else begin
      want = expected_reports.pop_front();
      diff = "";
      if (got.bin_total != want.bin_total) diff = {diff, " bin_total"};
      if (got.bin_wrong != want.bin_wrong) diff = {diff, " bin_wrong"};
      if (got.bases_done != want.bases_done) diff = {diff, " bases_done"};
      if (got.good_count != want.good_count) diff = {diff, " good_count"};
      if (got.error_count != want.error_count) diff = {diff, " error_count"};
      if (got.max_quality != want.max_quality) diff = {diff, " max_quality"};
      if (diff != "") flag_failure({"field(s)", diff}, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      expected_reports.delete();
      fails = 0;
      reports_seen = 0;
    end else begin
      // A result can never leave in the cycle its request enters, so results
      // are matched before the new input beat is predicted.
      if (out_mon.valid && out_mon.ready) begin
        reports_seen++;
        check_report('{bin_total: out_mon.bin_total, bin_wrong: out_mon.bin_wrong,
                       bases_done: out_mon.bases_done, good_count: out_mon.good_count,
                       error_count: out_mon.error_count, max_quality: out_mon.max_quality});
      end
      if (in_mon.valid && in_mon.ready)
        apply_input_beat(in_mon.opcode, in_mon.base_char, in_mon.quality, in_mon.matched,
                         in_mon.bin_index);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[2])
          REG_BIN_SIZE:  bin_size = pwdata_i[QW-1:0];
          REG_PYRO_MODE: pyro_mode = pwdata_i[0];
          default: begin
          end
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o <= expected_reports.size();
    reports_o <= reports_seen;
  end

endmodule

// ----- test/tb_quality_error_histogram_unit.sv -----
`timescale 1ns / 1ps
module tb_quality_error_histogram_unit;
  import qeh_pkg::*;

  // Opcode 3 has no member in the package; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned RESET_CYCLES = 12;
  // Quiet cycles after the last expected result before a register write or
  // the verdict: covers a base or flush still working in the back end.
  localparam int unsigned SETTLE_CYCLES = 40;
  // Long output hold-off used once to fill the block and stall its input.
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 225;
  localparam int unsigned NUM_PHASES = 6;
  // Several times the slowest legal run.
  localparam int unsigned TIMEOUT_NS = 4_000_000;

  localparam logic [CHW-1:0] ALPHABET [5] = '{8'h41, 8'h43, 8'h47, 8'h54, GAP_CHAR};

  typedef struct packed {
    logic [1:0]      op;
    logic [CHW-1:0]  ch;
    logic [QW-1:0]   q;
    logic            m;
    logic [IDXW-1:0] idx;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  qeh_in_if  in_ch ();
  qeh_out_if out_ch ();

  // Receiver side: its own process, so the long hold-off can run while the
  // stimulus keeps offering input beats.
  logic        recv_ready = 1'b0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;

  int unsigned send_idle_pct;
  int unsigned beats_sent;
  int unsigned reg_writes;

  int unsigned chk_fails;
  int unsigned chk_pending;
  int unsigned chk_reports;

  assign out_ch.ready = recv_ready;

  always #5 clk_i = ~clk_i;

  quality_error_histogram_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  qeh_histogram_checker hist_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (chk_fails),
    .pending_o    (chk_pending),
    .reports_o    (chk_reports)
  );

  // The hold-off starts once when requested and then counts its cycles down;
  // otherwise ready follows the stall percentage of the current phase.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      recv_ready <= 1'b0;
    end else if (hold_left != 0) begin
      recv_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      recv_ready <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end else begin
      recv_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Hard limit on the run.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d result beats still expected", chk_pending);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic beat_t base_beat(input logic [CHW-1:0] ch, input logic [QW-1:0] q,
                                      input logic m);
    return '{op: OP_BASE, ch: ch, q: q, m: m, idx: IDXW'($urandom)};
  endfunction

  // Control beats carry random filler in the fields the block does not use.
  function automatic beat_t ctl_beat(input logic [1:0] op, input logic [IDXW-1:0] idx);
    return '{op: op, ch: CHW'($urandom), q: QW'($urandom), m: 1'($urandom), idx: idx};
  endfunction

  // All tasks below are entered right after a rising clock edge.
  task automatic send_beat(input beat_t b);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= b.op;
    in_ch.base_char <= b.ch;
    in_ch.quality <= b.q;
    in_ch.matched <= b.m;
    in_ch.bin_index <= b.idx;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // that ends the access cycle.
  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_writes++;
  endtask

  // Brings the block to idle: no input offered, every expected result out,
  // then a few quiet cycles for work that produces no result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [QW-1:0] pick_quality();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return QW'($urandom);
    endcase
  endfunction

  // Mostly well-formed reads: a run of bases drawn from a small alphabet with
  // frequent repeats (homopolymers), closed by an end beat and followed by a
  // few bin reads. The rest is single beats with fully random fields.
  task automatic random_traffic(input int unsigned count);
    int unsigned done;
    int unsigned len;
    logic [CHW-1:0] ch;
    beat_t noise;
    done = 0;
    ch = ALPHABET[0];
    while (done < count) begin
      if ($urandom_range(0, 99) < 80) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) ch = CHW'($urandom);
          else if ($urandom_range(0, 1) == 0) ch = ALPHABET[3'($urandom_range(0, 4))];
          send_beat(base_beat(ch, pick_quality(), $urandom_range(0, 99) >= 35));
        end
        send_beat(ctl_beat(OP_END, '0));
        done += len + 1;
        repeat ($urandom_range(0, 2)) begin
          send_beat(ctl_beat(OP_READ, IDXW'($urandom)));
          done++;
        end
      end else begin
        noise = beat_t'($urandom);
        send_beat(noise);
        // Ignored beats do not count toward the item budget.
        if (noise.op != OP_UNUSED) done++;
      end
    end
    // Close the window so no base waits across a register write.
    send_beat(ctl_beat(OP_END, '0));
  endtask

  initial begin
    logic [QW-1:0] bin_cfg;
    logic pyro_cfg;
    int unsigned mode;

    in_ch.valid <= 1'b0;
    in_ch.opcode <= '0;
    in_ch.base_char <= '0;
    in_ch.quality <= '0;
    in_ch.matched <= 1'b0;
    in_ch.bin_index <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    send_idle_pct = 0;
    beats_sent = 0;
    reg_writes = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset configuration (bin size 1, no homopolymer
    // charging): an empty read, field extremes, a gap, the unused opcode, a
    // flush, an end with an empty window and reads of the touched bins.
    send_beat(ctl_beat(OP_READ, '0));
    send_beat(base_beat(8'h41, '1, 1'b1));
    send_beat(base_beat('0, '0, 1'b0));
    send_beat(base_beat('1, '1, 1'b0));
    send_beat(base_beat(GAP_CHAR, 6'd42, 1'b0));
    send_beat('{op: OP_UNUSED, ch: '1, q: '1, m: 1'b1, idx: '1});
    send_beat(ctl_beat(OP_END, '0));
    send_beat(ctl_beat(OP_END, '1));
    send_beat(ctl_beat(OP_READ, '1));
    send_beat(ctl_beat(OP_READ, '0));
    send_beat(ctl_beat(OP_READ, 6'd42));
    drain();

    // Homopolymer cases: a mismatched first base keeps its own bin, an
    // interior mismatch takes the previous base's bin, then the next base's
    // bin, a gap never borrows, and a flushed last base keeps its own bin.
    write_reg(REG_PYRO_MODE, 32'd1);
    send_beat(base_beat(8'h47, 6'd10, 1'b0));
    send_beat(base_beat(8'h47, 6'd20, 1'b0));
    send_beat(base_beat(8'h43, 6'd30, 1'b0));
    send_beat(base_beat(8'h41, 6'd40, 1'b0));
    send_beat(base_beat(8'h41, 6'd50, 1'b1));
    send_beat(base_beat(GAP_CHAR, 6'd5, 1'b0));
    send_beat(base_beat(GAP_CHAR, 6'd6, 1'b1));
    send_beat(base_beat(8'h41, 6'd7, 1'b0));
    send_beat(ctl_beat(OP_END, '0));
    send_beat(ctl_beat(OP_READ, 6'd10));
    send_beat(ctl_beat(OP_READ, 6'd50));
    send_beat(ctl_beat(OP_READ, 6'd5));
    drain();

    // Random phases: each has its own configuration and idle pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin bin_cfg = 6'd3;  pyro_cfg = 1'b1; end
        1: begin bin_cfg = 6'd63; pyro_cfg = 1'b0; end
        2: begin bin_cfg = 6'd1;  pyro_cfg = 1'b1; end
        3: begin bin_cfg = 6'd0;  pyro_cfg = 1'b1; end
        4: begin bin_cfg = QW'($urandom_range(1, 63)); pyro_cfg = 1'($urandom); end
        default: begin bin_cfg = 6'd2; pyro_cfg = 1'b0; end
      endcase
      write_reg(REG_BIN_SIZE, 32'(bin_cfg));
      write_reg(REG_PYRO_MODE, 32'(pyro_cfg));

      mode = p % 4;
      send_idle_pct = (mode == 1) ? 85 : (mode == 3) ? 21 : 0;
      recv_stall_pct <= (mode == 2) ? 85 : (mode == 3) ? 21 : 0;
      // The first phase runs without idling, so the hold-off there lets the
      // block fill up while the sender offers a beat every cycle.
      if (p == 0) hold_req <= 1'b1;

      random_traffic(PHASE_ITEMS);
      drain();
    end

    $display("Run covered %0d input beats, %0d result beats, %0d register writes.",
             beats_sent, chk_reports, reg_writes);
    $display("Bin sizes 0, 1, 2, 3, 63 and one random, homopolymer mode on and off, "
             , "four idle patterns and one long output hold-off.");
    if (chk_fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatching result beats", chk_fails);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
